// ===== rtl/rth_pkg.sv =====
// RGB to HSL converter: shared constants, sector codes and the hue control struct.
// No dependencies; used by the interfaces, the front end, the back end and the top level.
`timescale 1ns / 1ps

package rth_pkg;

  localparam int HUE_W      = 15;
  localparam int SAT_W      = 17;
  localparam int LIGHT_W    = 17;
  localparam int FRAC_BITS  = 16;
  localparam int QUO_W      = 17;
  localparam int HUE_Q_W    = 12;
  localparam int HUE_SUM_W  = 16;
  localparam int HUE_SECTOR = 3840;
  localparam int HUE_TURN   = 23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic    neg;
    logic    grey;
  } hue_ctl_t;

endpackage

// ===== rtl/rth_if.sv =====
// RGB to HSL converter: valid/ready channel interfaces for pixels and results.
// Depends on rth_pkg for the result field widths.
`timescale 1ns / 1ps

interface rth_pix_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsl_if;
  logic                        valid;
  logic                        ready;
  logic [rth_pkg::HUE_W-1:0]   hue;
  logic [rth_pkg::SAT_W-1:0]   saturation;
  logic [rth_pkg::LIGHT_W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness, input ready);
  modport sink   (input valid, input hue, input saturation, input lightness, output ready);
endinterface

// ===== rtl/rth_front.sv =====
// RGB to HSL converter: two front stages, max/min and sector choice, then divider operands
// and lightness. Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_front #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                        clk,
  input  logic [1:0]                                  en,
  input  logic [CHANNEL_BITS-1:0]                     red,
  input  logic [CHANNEL_BITS-1:0]                     green,
  input  logic [CHANNEL_BITS-1:0]                     blue,
  output rth_pkg::hue_ctl_t                           hctl,
  output logic [CHANNEL_BITS+rth_pkg::QUO_W-1:0]      hue_num,
  output logic [CHANNEL_BITS-1:0]                     hue_den,
  output logic [CHANNEL_BITS+rth_pkg::QUO_W-1:0]      sat_num,
  output logic [CHANNEL_BITS-1:0]                     sat_den,
  output logic [rth_pkg::LIGHT_W-1:0]                 light
);

  localparam int CB    = CHANNEL_BITS;
  localparam int PW    = CB + rth_pkg::HUE_Q_W;
  localparam int NUM_W = CB + rth_pkg::QUO_W;
  localparam int LPW      = 2 * CB + 18;
  localparam int LIGHT_SH = 2 * CB + 1;
  localparam longint FULL_L    = (longint'(1) << CB) - 1;
  localparam longint LIGHT_MUL = ((longint'(1) << (2 * CB + 16)) + FULL_L - 1) / FULL_L;
  localparam logic [CB-1:0] FULL     = {CB{1'b1}};
  localparam logic [CB:0]   TWO_FULL = {FULL, 1'b0};

  rth_pkg::sector_t  sec;
  logic [CB-1:0]     hi;
  logic [CB-1:0]     lo;
  logic [CB:0]       diff;
  logic [CB:0]       diff_neg;

  rth_pkg::hue_ctl_t hctl1_nxt, hctl1_r;
  logic [CB-1:0]     c_nxt, c_r;
  logic [CB:0]       sum_nxt, sum_r;
  logic [CB-1:0]     dmag_nxt, dmag_r;

  logic [PW-1:0]     hue_prod;
  logic [LPW-1:0]    light_prod;
  rth_pkg::hue_ctl_t hctl2_r;
  logic [NUM_W-1:0]  hue_num_nxt, hue_num_r;
  logic [CB-1:0]     hue_den_r;
  logic [NUM_W-1:0]  sat_num_nxt, sat_num_r;
  logic [CB-1:0]     sat_den_nxt, sat_den_r;
  logic [rth_pkg::LIGHT_W-1:0] light_nxt, light_r;

  // stage 1: largest channel picks the sector, red first, then green
  always_comb begin
    if (red >= green && red >= blue) begin
      sec  = rth_pkg::SEC_RED;
      hi   = red;
      lo   = (green < blue) ? green : blue;
      diff = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      sec  = rth_pkg::SEC_GREEN;
      hi   = green;
      lo   = (red < blue) ? red : blue;
      diff = {1'b0, blue} - {1'b0, red};
    end else begin
      sec  = rth_pkg::SEC_BLUE;
      hi   = blue;
      lo   = (red < green) ? red : green;
      diff = {1'b0, red} - {1'b0, green};
    end
    diff_neg         = -diff;
    c_nxt            = hi - lo;
    sum_nxt          = {1'b0, hi} + {1'b0, lo};
    dmag_nxt         = diff[CB] ? diff_neg[CB-1:0] : diff[CB-1:0];
    hctl1_nxt.sector = sec;
    hctl1_nxt.neg    = diff[CB];
    hctl1_nxt.grey   = (c_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hctl1_r <= hctl1_nxt;
      c_r     <= c_nxt;
      sum_r   <= sum_nxt;
      dmag_r  <= dmag_nxt;
    end
  end

  // stage 2: numerators, divisors and lightness by reciprocal multiplication
  always_comb begin
    hue_prod      = PW'(dmag_r) * PW'(rth_pkg::HUE_SECTOR);
    hue_num_nxt   = {{(rth_pkg::QUO_W - rth_pkg::HUE_Q_W){1'b0}}, hue_prod};
    sat_num_nxt   = {1'b0, c_r, {rth_pkg::FRAC_BITS{1'b0}}};
    light_prod    = LPW'(sum_r) * LPW'(LIGHT_MUL);
    light_nxt     = light_prod[LPW-1:LIGHT_SH];
    if (sum_r >= {1'b0, FULL}) begin
      sat_den_nxt = CB'(TWO_FULL - sum_r);
    end else begin
      sat_den_nxt = sum_r[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hctl2_r     <= hctl1_r;
      hue_num_r   <= hue_num_nxt;
      hue_den_r   <= c_r;
      sat_num_r   <= sat_num_nxt;
      sat_den_r   <= sat_den_nxt;
      light_r     <= light_nxt;
    end
  end

  assign hctl      = hctl2_r;
  assign hue_num   = hue_num_r;
  assign hue_den   = hue_den_r;
  assign sat_num   = sat_num_r;
  assign sat_den   = sat_den_r;
  assign light     = light_r;

endmodule

// ===== rtl/rth_divider.sv =====
// RGB to HSL converter: pipelined restoring divider lane, one quotient bit per stage.
// Needs num < den * 2**QUO_W. No package dependency; stage enables come from the top level.
`timescale 1ns / 1ps

module rth_divider #(
  parameter int DEN_W = 8,
  parameter int QUO_W = 17
) (
  input  logic                   clk,
  input  logic [QUO_W-1:0]       en,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo,
  output logic [DEN_W-1:0]       rem
);

  localparam int ACC_W = DEN_W + QUO_W;

  logic [ACC_W-1:0] acc_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W-1];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [ACC_W-1:0] acc_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   cand;
    logic [DEN_W:0]   diff;
    logic [ACC_W-1:0] acc_nxt;

    if (i == 0) begin : g_first
      assign acc_in = num;
      assign den_in = den;
    end else begin : g_next
      assign acc_in = acc_r[i-1];
      assign den_in = den_r[i-1];
    end

    always_comb begin
      cand = acc_in[ACC_W-1:QUO_W-1];
      diff = cand - {1'b0, den_in};
      if (cand >= {1'b0, den_in}) begin
        acc_nxt = {diff[DEN_W-1:0], acc_in[QUO_W-2:0], 1'b1};
      end else begin
        acc_nxt = {cand[DEN_W-1:0], acc_in[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        acc_r[i] <= acc_nxt;
      end
    end

    if (i < QUO_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en[i]) begin
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = acc_r[QUO_W-1][QUO_W-1:0];
  assign rem = acc_r[QUO_W-1][ACC_W-1:QUO_W];

endmodule

// ===== rtl/rth_back.sv =====
// RGB to HSL converter: final stage, hue floor correction, sector offset, wrap and grey case.
// Depends on rth_pkg; drives the result register.
`timescale 1ns / 1ps

module rth_back (
  input  logic                          clk,
  input  logic                          en,
  input  rth_pkg::hue_ctl_t             hctl,
  input  logic [rth_pkg::HUE_Q_W-1:0]   hue_quo,
  input  logic                          hue_rem_nz,
  input  logic [rth_pkg::SAT_W-1:0]     sat_quo,
  input  logic [rth_pkg::LIGHT_W-1:0]   light_quo,
  output logic [rth_pkg::HUE_W-1:0]     hue,
  output logic [rth_pkg::SAT_W-1:0]     saturation,
  output logic [rth_pkg::LIGHT_W-1:0]   lightness
);

  localparam int SW = rth_pkg::HUE_SUM_W;

  logic [SW-1:0]               mag;
  logic [SW-1:0]               offset;
  logic [SW-1:0]               hsum;
  logic [SW-1:0]               hwrap;
  logic [rth_pkg::HUE_W-1:0]   hue_nxt, hue_r;
  logic [rth_pkg::SAT_W-1:0]   sat_nxt, sat_r;
  logic [rth_pkg::LIGHT_W-1:0] light_r;

  always_comb begin
    case (hctl.sector)
      rth_pkg::SEC_RED:   offset = '0;
      rth_pkg::SEC_GREEN: offset = SW'(2 * rth_pkg::HUE_SECTOR);
      rth_pkg::SEC_BLUE:  offset = SW'(4 * rth_pkg::HUE_SECTOR);
      default:            offset = '0;
    endcase
    // floor of a negative quotient rounds the magnitude up
    mag   = SW'(hue_quo) + SW'(hctl.neg & hue_rem_nz);
    hsum  = hctl.neg ? (offset - mag) : (offset + mag);
    hwrap = hsum[SW-1] ? (hsum + SW'(rth_pkg::HUE_TURN)) : hsum;
    if (hctl.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = hwrap[rth_pkg::HUE_W-1:0];
      sat_nxt = sat_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= light_quo;
    end
  end

  assign hue        = hue_r;
  assign saturation = sat_r;
  assign lightness  = light_r;

endmodule

// ===== rtl/rgb_to_hsl_converter_top.sv =====
// RGB to HSL converter top level: stage valid chain, divider lanes and result channel.
// Depends on rth_pkg, rth_if, rth_front, rth_divider and rth_back.
//
// Usage: pixels enter on in_pix (red, green, blue) with a valid/ready
// handshake; each accepted transaction gives exactly one result on out_hsl
// (hue in degrees times 64, saturation and lightness as Q1.16 fractions).
// Pipeline: two front stages (lightness is formed there by a reciprocal
// multiplication), seventeen divider stages (one quotient bit per stage in
// two parallel restoring divider lanes, hue and saturation) and one result
// register: 20 register stages in all.
// Throughput is one pixel per cycle while the receiver accepts results.
// Every stage keeps its own valid bit and loads when it is empty or its
// successor loads, so a stalled receiver holds the result register while
// empty stages further back keep taking pixels; nothing is dropped or
// repeated. Reset (rst_n low, synchronous) clears all valid bits; data
// registers are not reset. The block holds no state between pixels.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_top #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  rth_pix_if.sink          in_pix,
  rth_hsl_if.source        out_hsl
);

  localparam int CB       = CHANNEL_BITS;
  localparam int QW       = rth_pkg::QUO_W;
  localparam int FRONT_ST = 2;
  localparam int STAGES   = FRONT_ST + QW + 1;

  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] vld_nxt, vld_r;

  rth_pkg::hue_ctl_t    front_hctl;
  rth_pkg::hue_ctl_t    hctl_r [QW];
  logic [rth_pkg::LIGHT_W-1:0] front_light;
  logic [rth_pkg::LIGHT_W-1:0] light_r [QW];
  logic [CB+QW-1:0]     hue_num;
  logic [CB-1:0]        hue_den;
  logic [CB+QW-1:0]     sat_num;
  logic [CB-1:0]        sat_den;
  logic [QW-1:0]        hue_quo;
  logic [CB-1:0]        hue_rem;
  logic [QW-1:0]        sat_quo;

  // a stage advances when empty or when its successor advances
  assign rdy[STAGES] = out_hsl.ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_rdy
    assign rdy[i] = ~vld_r[i] | rdy[i+1];
  end

  assign vld_nxt = (rdy[STAGES-1:0] & {vld_r[STAGES-2:0], in_pix.valid})
                 | (~rdy[STAGES-1:0] & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  rth_front #(
    .CHANNEL_BITS (CB)
  ) u_front (
    .clk       (clk),
    .en        (rdy[1:0]),
    .red       (in_pix.red),
    .green     (in_pix.green),
    .blue      (in_pix.blue),
    .hctl      (front_hctl),
    .hue_num   (hue_num),
    .hue_den   (hue_den),
    .sat_num   (sat_num),
    .sat_den   (sat_den),
    .light     (front_light)
  );

  // hue control and lightness travel alongside the divider stages
  for (genvar j = 0; j < QW; j++) begin : g_hctl
    always_ff @(posedge clk) begin
      if (rdy[FRONT_ST+j]) begin
        hctl_r[j]  <= (j == 0) ? front_hctl : hctl_r[(j == 0) ? 0 : j-1];
        light_r[j] <= (j == 0) ? front_light : light_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  rth_divider #(
    .DEN_W (CB),
    .QUO_W (QW)
  ) u_div_hue (
    .clk (clk),
    .en  (rdy[FRONT_ST+QW-1:FRONT_ST]),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo),
    .rem (hue_rem)
  );

  rth_divider #(
    .DEN_W (CB),
    .QUO_W (QW)
  ) u_div_sat (
    .clk (clk),
    .en  (rdy[FRONT_ST+QW-1:FRONT_ST]),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo),
    .rem ()
  );

  rth_back u_back (
    .clk        (clk),
    .en         (rdy[STAGES-1]),
    .hctl       (hctl_r[QW-1]),
    .hue_quo    (hue_quo[rth_pkg::HUE_Q_W-1:0]),
    .hue_rem_nz (|hue_rem),
    .sat_quo    (sat_quo),
    .light_quo  (light_r[QW-1]),
    .hue        (out_hsl.hue),
    .saturation (out_hsl.saturation),
    .lightness  (out_hsl.lightness)
  );

  assign in_pix.ready  = rdy[0];
  assign out_hsl.valid = vld_r[STAGES-1];

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> vld_r[0])
    else $error("accepted transaction not captured by the first stage");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> out_hsl.hue < rth_pkg::HUE_W'(rth_pkg::HUE_TURN))
    else $error("hue outside one turn");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> (out_hsl.saturation <= rth_pkg::SAT_W'(65536))
                   && (out_hsl.lightness <= rth_pkg::LIGHT_W'(65536)))
    else $error("saturation or lightness above one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid && !out_hsl.ready |=> out_hsl.valid && $stable(out_hsl.hue))
    else $error("result register changed while stalled");

endmodule
